// ===== rtl/core/pdfsc_pkg.sv =====
// pdfsc_pkg: shared types and constants for the pdf stream carver
// no dependencies; used by every module under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package pdfsc_pkg;

  localparam int WIN_DEPTH = 13;
  localparam int WIN_BITS  = 8 * WIN_DEPTH;

  typedef logic [3:0] fill_t;
  typedef logic [WIN_BITS-1:0] win_t;

  localparam fill_t FILL_FULL = 4'd13;
  localparam fill_t HOLD_FULL = 4'd10;

  typedef enum logic [1:0] {
    MODE_OUTSIDE = 2'd0,
    MODE_DICT    = 2'd1,
    MODE_STREAM  = 2'd2,
    MODE_TAIL    = 2'd3
  } mode_t;

  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_NO_ENDOBJ     = 2'd1;
  localparam logic [1:0] ERR_NO_ENDSTREAM  = 2'd2;

  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_J    = "j";
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";

  // last character sits in the low byte
  localparam logic [8*3-1:0]  PAT_OBJ        = "obj";
  localparam logic [8*6-1:0]  PAT_ENDOBJ     = "endobj";
  localparam logic [8*5-1:0]  PAT_ENDOB      = "endob";
  localparam logic [8*7-1:0]  PAT_STREAM     = "stream\n";
  localparam logic [8*9-1:0]  PAT_ENDSTREAM  = "endstream";
  localparam logic [8*8-1:0]  PAT_LENGTH     = "/Length ";
  localparam logic [8*13-1:0] PAT_FLATE_SP   = "/FlateDecode ";
  localparam logic [8*13-1:0] PAT_FLATE_LF   = "/FlateDecode\n";

  typedef struct packed {
    logic [7:0] data;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       flate_flag;
    logic [1:0] error_code;
  } res_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/pdfsc_in_reg.sv =====
// pdfsc_in_reg: input register stage holding one accepted byte transaction
// depends on pdfsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdfsc_in_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire pdfsc_pkg::in_item_t in_item,
  input  wire logic                advance,
  output logic                     stage_valid,
  output pdfsc_pkg::in_item_t      stage_item
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pdfsc_parser.sv =====
// pdfsc_parser: parse state, byte window and per-byte result logic
// depends on pdfsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdfsc_parser #(
  parameter int LENGTH_BITS = 31,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire pdfsc_pkg::in_item_t item,
  output logic                     res_valid,
  output pdfsc_pkg::res_flags_t    res,
  output logic [LENGTH_BITS-1:0]   res_length,
  output logic [INDEX_BITS-1:0]    res_index
);

  pdfsc_pkg::mode_t       mode, mode_next;
  pdfsc_pkg::win_t        win, win_next, win_push;
  pdfsc_pkg::fill_t       fill, fill_next, fill_push;
  logic                   flate_seen, flate_seen_next;
  logic [LENGTH_BITS-1:0] length_value, length_value_next;
  logic                   length_active, length_active_next;
  logic [INDEX_BITS-1:0]  stream_count, stream_count_next;
  logic                   halted, halted_next;

  logic [LENGTH_BITS+3:0] len_wide, len_scaled;
  logic                   len_sat;
  logic                   is_digit;

  assign win_push  = {win[pdfsc_pkg::WIN_BITS-9:0], item.data};
  assign fill_push = (fill >= pdfsc_pkg::FILL_FULL) ? pdfsc_pkg::FILL_FULL : fill + 4'd1;
  assign is_digit  = item.data inside {[pdfsc_pkg::CH_ZERO:pdfsc_pkg::CH_NINE]};

  // value * 10 + digit, saturating
  assign len_wide   = {4'b0000, length_value};
  assign len_scaled = (len_wide << 3) + (len_wide << 1)
                    + {{LENGTH_BITS{1'b0}}, item.data[3:0]};
  assign len_sat    = |len_scaled[LENGTH_BITS+3:LENGTH_BITS];

  always_comb begin
    mode_next          = mode;
    win_next           = win;
    fill_next          = fill;
    flate_seen_next    = flate_seen;
    length_value_next  = length_value;
    length_active_next = length_active;
    stream_count_next  = stream_count;
    halted_next        = halted;
    res_valid          = 1'b0;
    res                = '0;
    if (item.end_of_input) begin
      if (!halted && mode != pdfsc_pkg::MODE_OUTSIDE) begin
        res_valid         = 1'b1;
        res.end_of_stream = (mode == pdfsc_pkg::MODE_STREAM);
        res.error_code    = pdfsc_pkg::ERR_NO_ENDOBJ;
      end
      mode_next          = pdfsc_pkg::MODE_OUTSIDE;
      fill_next          = '0;
      flate_seen_next    = 1'b0;
      length_value_next  = '0;
      length_active_next = 1'b0;
      halted_next        = 1'b0;
    end else if (!halted) begin
      case (mode)
        pdfsc_pkg::MODE_OUTSIDE: begin
          win_next  = win_push;
          fill_next = fill_push;
          if (fill_push >= 4'd3 && win_push[8*3-1:0] == pdfsc_pkg::PAT_OBJ) begin
            mode_next          = pdfsc_pkg::MODE_DICT;
            fill_next          = '0;
            flate_seen_next    = 1'b0;
            length_value_next  = '0;
            length_active_next = 1'b0;
          end
        end
        pdfsc_pkg::MODE_DICT: begin
          if (length_active) begin
            if (is_digit) begin
              length_value_next = len_sat ? {LENGTH_BITS{1'b1}}
                                          : len_scaled[LENGTH_BITS-1:0];
            end else begin
              length_active_next = 1'b0;
            end
          end
          win_next  = win_push;
          fill_next = fill_push;
          if (fill_push >= 4'd6 && win_push[8*6-1:0] == pdfsc_pkg::PAT_ENDOBJ) begin
            mode_next = pdfsc_pkg::MODE_OUTSIDE;
            fill_next = '0;
          end else if (fill_push >= 4'd7 &&
                       win_push[8*7-1:0] == pdfsc_pkg::PAT_STREAM) begin
            mode_next          = pdfsc_pkg::MODE_STREAM;
            fill_next          = '0;
            length_active_next = 1'b0;
            if (stream_count != {INDEX_BITS{1'b1}}) begin
              stream_count_next = stream_count + INDEX_BITS'(1);
            end
          end else if (fill_push >= 4'd8 &&
                       win_push[8*8-1:0] == pdfsc_pkg::PAT_LENGTH) begin
            length_value_next  = '0;
            length_active_next = 1'b1;
          end else if (fill_push >= 4'd13 &&
                       (win_push[8*13-1:0] == pdfsc_pkg::PAT_FLATE_SP ||
                        win_push[8*13-1:0] == pdfsc_pkg::PAT_FLATE_LF)) begin
            flate_seen_next = 1'b1;
          end
        end
        pdfsc_pkg::MODE_STREAM: begin
          if (item.data == pdfsc_pkg::CH_LF && fill >= 4'd9 &&
              win[8*9-1:0] == pdfsc_pkg::PAT_ENDSTREAM) begin
            res_valid         = 1'b1;
            res.end_of_stream = 1'b1;
            if (fill == pdfsc_pkg::HOLD_FULL) begin
              res.has_data  = 1'b1;
              res.data_byte = win[8*10-1:8*9];
            end
            mode_next = pdfsc_pkg::MODE_TAIL;
            fill_next = '0;
          end else if (item.data == pdfsc_pkg::CH_J && fill >= 4'd5 &&
                       win[8*5-1:0] == pdfsc_pkg::PAT_ENDOB) begin
            res_valid         = 1'b1;
            res.end_of_stream = 1'b1;
            res.error_code    = pdfsc_pkg::ERR_NO_ENDSTREAM;
            halted_next       = 1'b1;
            fill_next         = '0;
          end else begin
            win_next = win_push;
            if (fill == pdfsc_pkg::HOLD_FULL) begin
              res_valid     = 1'b1;
              res.has_data  = 1'b1;
              res.data_byte = win[8*10-1:8*9];
            end else begin
              fill_next = fill + 4'd1;
            end
          end
        end
        pdfsc_pkg::MODE_TAIL: begin
          win_next  = win_push;
          fill_next = fill_push;
          if (fill_push >= 4'd6 && win_push[8*6-1:0] == pdfsc_pkg::PAT_ENDOBJ) begin
            mode_next = pdfsc_pkg::MODE_OUTSIDE;
            fill_next = '0;
          end
        end
        default: begin
          mode_next = pdfsc_pkg::MODE_OUTSIDE;
        end
      endcase
    end
    res.flate_flag = res.end_of_stream & flate_seen;
  end

  assign res_length = res.end_of_stream ? length_value : '0;
  assign res_index  = res.end_of_stream ? stream_count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= pdfsc_pkg::MODE_OUTSIDE;
      fill          <= '0;
      flate_seen    <= 1'b0;
      length_value  <= '0;
      length_active <= 1'b0;
      stream_count  <= '0;
      halted        <= 1'b0;
    end else if (fire) begin
      mode          <= mode_next;
      fill          <= fill_next;
      flate_seen    <= flate_seen_next;
      length_value  <= length_value_next;
      length_active <= length_active_next;
      stream_count  <= stream_count_next;
      halted        <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      win <= win_next;
    end
  end

  a_halt_in_stream: assert property (@(posedge clk) disable iff (rst)
    halted |-> mode == pdfsc_pkg::MODE_STREAM)
    else $error("halted outside stream mode");

  a_hold_depth: assert property (@(posedge clk) disable iff (rst)
    mode == pdfsc_pkg::MODE_STREAM |-> fill <= pdfsc_pkg::HOLD_FULL)
    else $error("stream hold overfilled");

  a_fill_depth: assert property (@(posedge clk) disable iff (rst)
    fill <= pdfsc_pkg::FILL_FULL)
    else $error("window fill out of range");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && !res.has_data) |->
      (res.end_of_stream || res.error_code != pdfsc_pkg::ERR_NONE))
    else $error("empty result with no end mark or error");

  a_halt_stays: assert property (@(posedge clk) disable iff (rst)
    (halted && !(fire && item.end_of_input)) |=> halted)
    else $error("halt released without end of input");

endmodule

`default_nettype wire

// ===== rtl/core/pdfsc_out_reg.sv =====
// pdfsc_out_reg: result register facing the output channel
// depends on pdfsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdfsc_out_reg #(
  parameter int LENGTH_BITS = 31,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire pdfsc_pkg::res_flags_t  res_in,
  input  wire logic [LENGTH_BITS-1:0] length_in,
  input  wire logic [INDEX_BITS-1:0]  index_in,
  input  wire logic                   out_ready,
  output logic                        out_valid,
  output pdfsc_pkg::res_flags_t       res_out,
  output logic [LENGTH_BITS-1:0]      length_out,
  output logic [INDEX_BITS-1:0]       index_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out    <= res_in;
      length_out <= length_in;
      index_out  <= index_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pdf_stream_carver.sv =====
// pdf_stream_carver: top level joining input register, parser and result register
// depends on pdfsc_pkg, pdfsc_in_reg, pdfsc_parser, pdfsc_out_reg
`timescale 1ns / 1ps
`default_nettype none

// Takes a PDF file one byte per transaction and returns the raw bytes of each
// object stream, with the last byte (or an empty closing result) marked by
// end_of_stream and carrying the FlateDecode flag, the /Length value and the
// stream count. Stream bytes leave ten bytes behind the input so the
// endstream terminator is never passed on. One byte is taken every cycle
// while the output is not stalled; a result passes from the input register
// through the parse logic into the result register. While a result waits on
// out_ready, the byte in the input register waits as well, so a stalled
// output holds one byte inside the block before in_ready drops.
module pdf_stream_carver #(
  parameter int LENGTH_BITS = 31,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             byte_in,
  input  wire logic                   end_of_input,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        has_data,
  output logic [7:0]                  data_byte,
  output logic                        end_of_stream,
  output logic                        flate_flag,
  output logic [LENGTH_BITS-1:0]      declared_length,
  output logic [INDEX_BITS-1:0]       stream_index,
  output logic [1:0]                  error_code
);

  pdfsc_pkg::in_item_t   in_item, stage_item;
  pdfsc_pkg::res_flags_t res, res_q;
  logic                  stage_valid, stage_fire, res_valid;
  logic [LENGTH_BITS-1:0] res_length;
  logic [INDEX_BITS-1:0]  res_index;

  assign in_item.data         = byte_in;
  assign in_item.end_of_input = end_of_input;
  assign stage_fire           = stage_valid && (!out_valid || out_ready);

  pdfsc_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .advance     (stage_fire),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  pdfsc_parser #(
    .LENGTH_BITS (LENGTH_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (stage_fire),
    .item       (stage_item),
    .res_valid  (res_valid),
    .res        (res),
    .res_length (res_length),
    .res_index  (res_index)
  );

  pdfsc_out_reg #(
    .LENGTH_BITS (LENGTH_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (stage_fire && res_valid),
    .res_in     (res),
    .length_in  (res_length),
    .index_in   (res_index),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .res_out    (res_q),
    .length_out (declared_length),
    .index_out  (stream_index)
  );

  assign has_data      = res_q.has_data;
  assign data_byte     = res_q.data_byte;
  assign end_of_stream = res_q.end_of_stream;
  assign flate_flag    = res_q.flate_flag;
  assign error_code    = res_q.error_code;

endmodule

`default_nettype wire
